@@ hdl/tree_lca_binary_lifting_defines.svh @@
// Assertion macros shared by the lowest-common-ancestor block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TLCA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLCA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/tlca_pkg.sv @@
// Shared constants and types of the lowest-common-ancestor block.
// Used by the top level; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlca_pkg;

  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = $clog2(NODES);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TBL_DEPTH = LEVELS * NODES;
  localparam int DEPTH_W   = 10;
  localparam int DIST_W    = 11;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int ANC_W     = NODE_W + 1;
  localparam int S_TDATA_W = ((2 * NODE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NODE_W + DIST_W + 7) / 8) * 8;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(1023);
  localparam logic [DIST_W-1:0]  DIST_MAX  = DIST_W'(2046);
  localparam logic [LVL_W-1:0]   LVL_TOP   = LVL_W'(LEVELS - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_NODE   = 2'd1,
    STAT_NO_PARENT = 2'd2
  } stat_e;

  // One ancestor table entry: valid flag over the ancestor index.
  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] idx;
  } anc_t;

endpackage
`default_nettype wire

@@ hdl/tlca_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/tree_lca_binary_lifting.sv @@
// Load: the result waits on the chain of dependent ancestor table reads, one read per level
// that exists; levels past the root are written without a read.
// Query: a node that is not loaded gives a status without lifting; else the deeper node is lifted
// to the depth of the other, then both are lifted together in joint passes until they meet.
// One item is in work at a time; the next request is taken the cycle after the result registers.
// After reset and each clear item the loaded flags are swept; tables are kept.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_lca_binary_lifting_defines.svh"
module tree_lca_binary_lifting (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // root node register
  input  wire logic                               cfg_we_i,
  input  wire logic [tlca_pkg::NODE_W-1:0]        cfg_wdata_i,
  // request stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [tlca_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // first_node, second_node
  input  wire logic [tlca_pkg::KIND_W-1:0]        s_axis_tuser,  // kind
  // result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [tlca_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // ancestor, distance
  output logic      [tlca_pkg::STAT_W-1:0]        m_axis_tuser   // status
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_LD_RD, ST_LD_CHK, ST_LD_WR, ST_LD_RD2, ST_LD_GET,
    ST_Q_RDA, ST_Q_RDB, ST_Q_CHK, ST_LF_TEST, ST_LF_GET, ST_EQ,
    ST_UP_RDU, ST_UP_RDV, ST_UP_CMP, ST_FIN_RD, ST_FIN_GET,
    ST_DEP_RD, ST_DIST, ST_RESP
  } state_e;

  localparam int NW = tlca_pkg::NODE_W;
  localparam int DW = tlca_pkg::DEPTH_W;
  localparam int LW = tlca_pkg::LVL_W;

  state_e                    state_q;
  logic [NW-1:0]             root_q;
  logic [NW-1:0]             clr_q;
  logic [NW-1:0]             a_q, b_q, u_q, v_q;
  logic [LW-1:0]             lvl_q;
  logic [DW-1:0]             amt_q, da_q, db_q;
  tlca_pkg::anc_t            cur_q, au_q;
  logic                      la_q, moved_q;
  logic [NW-1:0]             res_anc_q;
  logic [tlca_pkg::DIST_W-1:0] res_dist_q;
  tlca_pkg::stat_e           res_stat_q;
  logic                      m_vld_q;
  logic [NW-1:0]             m_anc_q;
  logic [tlca_pkg::DIST_W-1:0] m_dist_q;
  tlca_pkg::stat_e           m_stat_q;

  // Memory ports
  logic                      tbl_we;
  logic [LW+NW-1:0]          tbl_waddr, tbl_raddr;
  tlca_pkg::anc_t            tbl_wdata, tbl_rd;
  logic [tlca_pkg::ANC_W-1:0] tbl_rdata;
  logic                      dep_we;
  logic [DW-1:0]             dep_wdata, dep_rd;
  logic [NW-1:0]             node_raddr;
  logic                      ld_we, ld_wdata, ld_rd;
  logic [NW-1:0]             ld_waddr;

  logic                      s_acc, s_take, root_hit, moved_nx, up_move;
  logic [DW-1:0]             dep_inc;
  logic signed [DW+1:0]      dist_s;
  logic [tlca_pkg::DIST_W-1:0] dist_c;

  assign tbl_rd   = tlca_pkg::anc_t'(tbl_rdata);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  // A request of a defined kind leaves the idle state.
  assign s_take   = s_acc && (s_axis_tuser <= tlca_pkg::KIND_CLEAR);
  assign root_hit = (a_q == root_q);
  assign dep_inc  = (dep_rd == tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX : dep_rd + DW'(1);
  assign up_move  = au_q.vld && tbl_rd.vld && (au_q.idx != tbl_rd.idx);
  assign moved_nx = moved_q || up_move;

  // Path length through the common ancestor, clamped to the result range.
  assign dist_s = $signed({2'b00, da_q}) + $signed({2'b00, db_q})
                - $signed({1'b0, dep_rd, 1'b0});
  always_comb begin
    if (dist_s < 0) begin
      dist_c = '0;
    end else if (dist_s > $signed({1'b0, tlca_pkg::DIST_MAX})) begin
      dist_c = tlca_pkg::DIST_MAX;
    end else begin
      dist_c = dist_s[tlca_pkg::DIST_W-1:0];
    end
  end

  // Memory address and write control per state.
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = {lvl_q, a_q};
    tbl_wdata  = cur_q;
    tbl_raddr  = {lvl_q, u_q};
    dep_we     = 1'b0;
    dep_wdata  = root_hit ? '0 : dep_inc;
    node_raddr = b_q;
    ld_we      = 1'b0;
    ld_waddr   = a_q;
    ld_wdata   = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        ld_we    = 1'b1;
        ld_waddr = clr_q;
        ld_wdata = 1'b0;
      end
      ST_LD_CHK: dep_we = root_hit || ld_rd;
      ST_LD_WR: begin
        tbl_we = 1'b1;
        ld_we  = (lvl_q == tlca_pkg::LVL_TOP);
      end
      ST_LD_RD2: tbl_raddr = {lvl_q, cur_q.idx};
      ST_Q_RDA:  node_raddr = a_q;
      ST_UP_RDV: tbl_raddr = {lvl_q, v_q};
      ST_FIN_RD: tbl_raddr = {LW'(0), u_q};
      ST_DEP_RD: node_raddr = u_q;
      default: ;
    endcase
  end

  // Control sequencer, result and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      root_q     <= '0;
      m_vld_q    <= 1'b0;
      lvl_q      <= '0;
      moved_q    <= 1'b0;
      res_stat_q <= tlca_pkg::STAT_OK;
      m_stat_q   <= tlca_pkg::STAT_OK;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (m_vld_q && m_axis_tready && (state_q != ST_RESP)) begin
        m_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + NW'(1);
          if (clr_q == NW'(tlca_pkg::NODES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_acc) begin
            a_q        <= s_axis_tdata[NW-1:0];
            b_q        <= s_axis_tdata[2*NW-1:NW];
            res_anc_q  <= '0;
            res_dist_q <= '0;
            unique case (s_axis_tuser)
              tlca_pkg::KIND_LOAD:  state_q <= ST_LD_RD;
              tlca_pkg::KIND_QUERY: state_q <= ST_Q_RDA;
              tlca_pkg::KIND_CLEAR: begin
                clr_q   <= '0;
                state_q <= ST_CLEAR;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_LD_RD: state_q <= ST_LD_CHK;
        ST_LD_CHK: begin
          lvl_q <= '0;
          if (root_hit) begin
            cur_q   <= '{vld: 1'b0, idx: '0};
            state_q <= ST_LD_WR;
          end else if (ld_rd) begin
            cur_q   <= '{vld: 1'b1, idx: b_q};
            state_q <= ST_LD_WR;
          end else begin
            res_stat_q <= tlca_pkg::STAT_NO_PARENT;
            state_q    <= ST_RESP;
          end
        end
        ST_LD_WR: begin
          if (lvl_q == tlca_pkg::LVL_TOP) begin
            res_stat_q <= tlca_pkg::STAT_OK;
            state_q    <= ST_RESP;
          end else if (cur_q.vld) begin
            state_q <= ST_LD_RD2;
          end else begin
            lvl_q <= lvl_q + LW'(1);
          end
        end
        ST_LD_RD2: begin
          lvl_q   <= lvl_q + LW'(1);
          state_q <= ST_LD_GET;
        end
        ST_LD_GET: begin
          cur_q   <= tbl_rd;
          state_q <= ST_LD_WR;
        end
        ST_Q_RDA: state_q <= ST_Q_RDB;
        ST_Q_RDB: begin
          la_q    <= ld_rd;
          da_q    <= dep_rd;
          state_q <= ST_Q_CHK;
        end
        ST_Q_CHK: begin
          db_q  <= dep_rd;
          lvl_q <= tlca_pkg::LVL_TOP;
          if (!la_q || !ld_rd) begin
            res_stat_q <= tlca_pkg::STAT_NO_NODE;
            state_q    <= ST_RESP;
          end else if (da_q < dep_rd) begin
            u_q     <= b_q;
            v_q     <= a_q;
            amt_q   <= dep_rd - da_q;
            state_q <= ST_LF_TEST;
          end else begin
            u_q     <= a_q;
            v_q     <= b_q;
            amt_q   <= da_q - dep_rd;
            state_q <= ST_LF_TEST;
          end
        end
        // Lift the deeper node, largest steps first.
        ST_LF_TEST: begin
          if ((amt_q >> lvl_q) != '0) begin
            state_q <= ST_LF_GET;
          end else if (lvl_q == '0) begin
            state_q <= ST_EQ;
          end else begin
            lvl_q <= lvl_q - LW'(1);
          end
        end
        ST_LF_GET: begin
          if (tbl_rd.vld) begin
            u_q     <= tbl_rd.idx;
            amt_q   <= amt_q - (DW'(1) << lvl_q);
            state_q <= ST_LF_TEST;
          end else if (lvl_q == '0) begin
            state_q <= ST_EQ;
          end else begin
            lvl_q   <= lvl_q - LW'(1);
            state_q <= ST_LF_TEST;
          end
        end
        ST_EQ: begin
          lvl_q   <= tlca_pkg::LVL_TOP;
          moved_q <= 1'b0;
          state_q <= (u_q == v_q) ? ST_DEP_RD : ST_UP_RDU;
        end
        // Lift both nodes together while their ancestors differ.
        ST_UP_RDU: state_q <= ST_UP_RDV;
        ST_UP_RDV: begin
          au_q    <= tbl_rd;
          state_q <= ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (up_move) begin
            u_q <= au_q.idx;
            v_q <= tbl_rd.idx;
          end
          if (lvl_q != '0) begin
            moved_q <= moved_nx;
            lvl_q   <= lvl_q - LW'(1);
            state_q <= ST_UP_RDU;
          end else if (moved_nx) begin
            moved_q <= 1'b0;
            lvl_q   <= tlca_pkg::LVL_TOP;
            state_q <= ST_UP_RDU;
          end else begin
            state_q <= ST_FIN_RD;
          end
        end
        ST_FIN_RD: state_q <= ST_FIN_GET;
        ST_FIN_GET: begin
          if (tbl_rd.vld) begin
            u_q <= tbl_rd.idx;
          end
          state_q <= ST_DEP_RD;
        end
        ST_DEP_RD: state_q <= ST_DIST;
        ST_DIST: begin
          res_anc_q  <= u_q;
          res_dist_q <= dist_c;
          res_stat_q <= tlca_pkg::STAT_OK;
          state_q    <= ST_RESP;
        end
        // Hand the result over once the output register is free.
        ST_RESP: begin
          if (!m_vld_q || m_axis_tready) begin
            m_vld_q  <= 1'b1;
            m_anc_q  <= res_anc_q;
            m_dist_q <= res_dist_q;
            m_stat_q <= res_stat_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {(tlca_pkg::M_TDATA_W - NW - tlca_pkg::DIST_W)'(0), m_dist_q, m_anc_q};
  assign m_axis_tuser  = m_stat_q;

  // Ancestor table: level in the upper address bits, node in the lower.
  tlca_ram #(
    .WIDTH (tlca_pkg::ANC_W),
    .DEPTH (tlca_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Node depth.
  tlca_ram #(
    .WIDTH (tlca_pkg::DEPTH_W),
    .DEPTH (tlca_pkg::NODES)
  ) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (a_q),
    .wdata_i (dep_wdata),
    .raddr_i (node_raddr),
    .rdata_o (dep_rd)
  );

  // Node loaded flags, swept clear after reset and on a clear request.
  tlca_ram #(
    .WIDTH (1),
    .DEPTH (tlca_pkg::NODES)
  ) u_ld_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .raddr_i (node_raddr),
    .rdata_o (ld_rd)
  );

  // Checks
  `TLCA_ASSERT_NEXT(a_one_at_a_time, s_take, !s_axis_tready, "request taken while busy")
  `TLCA_ASSERT_IMPL(a_dist_range, m_vld_q, m_dist_q <= tlca_pkg::DIST_MAX, "distance out of range")
  `TLCA_ASSERT_IMPL(a_lift_bound, (state_q == ST_LF_GET) && tbl_rd.vld, (amt_q >> lvl_q) != '0, "lift overshoots depth")
  `TLCA_ASSERT_NEXT(a_sweep_end, (state_q == ST_CLEAR) && (clr_q == NW'(tlca_pkg::NODES - 1)), state_q == ST_IDLE, "sweep did not end")

endmodule
`default_nettype wire
